// File: rtl/core/blvl_pkg.sv
// ----------------------------------------------------------------------------
// blvl_pkg
// Shared widths, register codes, config struct and level table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package blvl_pkg;

	// Field widths
	localparam int RAW_W      = 16;
	localparam int MV_W       = 16;
	localparam int PCT_W      = 7;
	localparam int REF_W      = 13;
	localparam int GAIN_W     = 3;
	localparam int RES_W      = 5;
	localparam int OHM_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Datapath widths
	localparam int P1_W  = RAW_W - 1 + REF_W;   // clamped raw times reference
	localparam int P2_W  = P1_W + GAIN_W;       // times inverse gain
	localparam int NUM_W = P2_W + OHM_W;        // divider numerator
	localparam int REM_W = OHM_W + MV_W;        // numerator when quotient fits

	// Divider pipeline: quotient bits resolved per stage
	localparam int DIV_STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES          = MV_W / DIV_STEPS_PER_STAGE;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_REF_MV   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INV = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RES_BITS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIV_EN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_RES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TAP_RES  = 3'd5;

	// Reset values
	localparam logic [REF_W-1:0]  RST_REF_MV   = 13'd600;
	localparam logic [GAIN_W-1:0] RST_GAIN_INV = 3'd6;
	localparam logic [RES_W-1:0]  RST_RES_BITS = 5'd14;
	localparam logic              RST_DIV_EN   = 1'b0;
	localparam logic [OHM_W-1:0]  RST_FULL_RES = 24'd1;
	localparam logic [OHM_W-1:0]  RST_TAP_RES  = 24'd1;

	typedef struct packed {
		logic [REF_W-1:0]  ref_mv;
		logic [GAIN_W-1:0] gain_inv;
		logic [RES_W-1:0]  res_bits;
		logic              div_en;
		logic [OHM_W-1:0]  full_res;
		logic [OHM_W-1:0]  tap_res;
	} cfg_t;

	// Interpolation widths
	localparam int D_W          = 9;    // mv offset into a segment, below 425
	localparam int SLOPE_W      = 5;    // percent span of a segment
	localparam int PROD_W       = 13;   // span times offset, below 6500
	localparam int RECIP_W      = 10;
	localparam int RECIP_SHIFT  = 16;
	localparam int RP_W         = PROD_W + RECIP_W;
	localparam int QEST_W       = 7;
	localparam int QD_W         = QEST_W + D_W;
	localparam int RECIP_ONE    = 1 << RECIP_SHIFT;

	// Segment lengths in mV and their fixed-point reciprocals
	localparam int SEG_A_DEN = 150;   // 3850..3999
	localparam int SEG_B_DEN = 190;   // 3660..3849
	localparam int SEG_C_DEN = 110;   // 3550..3659
	localparam int SEG_D_DEN = 325;   // 3225..3549
	localparam int SEG_E_DEN = 425;   // 2800..3224
	localparam int SEG_A_RCP = RECIP_ONE / SEG_A_DEN;
	localparam int SEG_B_RCP = RECIP_ONE / SEG_B_DEN;
	localparam int SEG_C_RCP = RECIP_ONE / SEG_C_DEN;
	localparam int SEG_D_RCP = RECIP_ONE / SEG_D_DEN;
	localparam int SEG_E_RCP = RECIP_ONE / SEG_E_DEN;

	typedef struct packed {
		logic [MV_W-1:0]    base_mv;
		logic [PCT_W-1:0]   base_pct;
		logic [SLOPE_W-1:0] slope;
		logic [D_W-1:0]     den;
		logic [RECIP_W-1:0] recip;
	} seg_t;

	function automatic seg_t seg_make(input int base_mv, input int base_pct,
		input int slope, input int den, input int recip);
		seg_t s;
		s.base_mv  = MV_W'(base_mv);
		s.base_pct = PCT_W'(base_pct);
		s.slope    = SLOPE_W'(slope);
		s.den      = D_W'(den);
		s.recip    = RECIP_W'(recip);
		return s;
	endfunction

	// Pick the table segment for a saturated mV value; flat ends get slope 0
	function automatic seg_t level_seg(input logic [MV_W-1:0] mv);
		seg_t s;
		if (mv >= MV_W'(4000))
			s = seg_make(0, 100, 0, 1, 0);
		else if (mv >= MV_W'(3850))
			s = seg_make(3850, 80, 20, SEG_A_DEN, SEG_A_RCP);
		else if (mv >= MV_W'(3660))
			s = seg_make(3660, 50, 30, SEG_B_DEN, SEG_B_RCP);
		else if (mv >= MV_W'(3550))
			s = seg_make(3550, 30, 20, SEG_C_DEN, SEG_C_RCP);
		else if (mv >= MV_W'(3225))
			s = seg_make(3225, 10, 20, SEG_D_DEN, SEG_D_RCP);
		else if (mv >= MV_W'(2800))
			s = seg_make(2800, 0, 5, SEG_E_DEN, SEG_E_RCP);
		else
			s = seg_make(0, 0, 0, 1, 0);
		return s;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/blvl_if.sv
// ----------------------------------------------------------------------------
// blvl_if
// Valid/ready channels: sample in, result out, config write.
// ----------------------------------------------------------------------------
`default_nettype none

interface blvl_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [blvl_pkg::RAW_W-1:0]    raw_sample;
	modport source (output valid, output raw_sample, input ready);
	modport sink   (input valid, input raw_sample, output ready);
endinterface

interface blvl_result_if;
	logic                        valid;
	logic                        ready;
	logic [blvl_pkg::MV_W-1:0]   battery_millivolts;
	logic [blvl_pkg::PCT_W-1:0]  level_percent;
	modport source (output valid, output battery_millivolts, output level_percent,
		input ready);
	modport sink   (input valid, input battery_millivolts, input level_percent,
		output ready);
endinterface

interface blvl_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [blvl_pkg::CFG_IDX_W-1:0]   index;
	logic [blvl_pkg::CFG_DATA_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/blvl_cfg.sv
// ----------------------------------------------------------------------------
// blvl_cfg
// Configuration register file; out-of-range indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module blvl_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            we,
	input  wire logic [blvl_pkg::CFG_IDX_W-1:0]  idx,
	input  wire logic [blvl_pkg::CFG_DATA_W-1:0] wdata,
	output blvl_pkg::cfg_t                       cfg
);
	import blvl_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ref_mv   <= RST_REF_MV;
			cfg_q.gain_inv <= RST_GAIN_INV;
			cfg_q.res_bits <= RST_RES_BITS;
			cfg_q.div_en   <= RST_DIV_EN;
			cfg_q.full_res <= RST_FULL_RES;
			cfg_q.tap_res  <= RST_TAP_RES;
		end else if (we) begin
			unique case (idx)
				REG_REF_MV:   cfg_q.ref_mv   <= wdata[REF_W-1:0];
				REG_GAIN_INV: cfg_q.gain_inv <= wdata[GAIN_W-1:0];
				REG_RES_BITS: cfg_q.res_bits <= wdata[RES_W-1:0];
				REG_DIV_EN:   cfg_q.div_en   <= wdata[0];
				REG_FULL_RES: cfg_q.full_res <= wdata[OHM_W-1:0];
				REG_TAP_RES:  cfg_q.tap_res  <= wdata[OHM_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/blvl_scale.sv
// ----------------------------------------------------------------------------
// blvl_scale
// Four stages: clamp and scale to mV, divider numerator, overflow check.
// ----------------------------------------------------------------------------
`default_nettype none

module blvl_scale (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic                               in_valid,
	input  wire logic signed [blvl_pkg::RAW_W-1:0]  raw_sample,
	input  blvl_pkg::cfg_t                          cfg,
	output logic                                    out_valid,
	output logic                                    out_sat,
	output logic [blvl_pkg::REM_W-1:0]              out_rem
);
	import blvl_pkg::*;

	logic [RAW_W-2:0] raw_pos;
	logic [P2_W-1:0]  p2;
	logic [OHM_W-1:0] full_eff;
	logic [OHM_W-1:0] tap_eff;

	logic             v_s1, v_s2, v_s3, v_s4;
	logic [P1_W-1:0]  p1_s1;
	logic [P2_W-1:0]  mv0_s2;
	logic [NUM_W-1:0] num_s3;
	logic             sat_s4;
	logic [REM_W-1:0] rem_s4;

	// negative readings count as zero
	assign raw_pos  = raw_sample[RAW_W-1] ? '0 : raw_sample[RAW_W-2:0];
	assign p2       = P2_W'(p1_s1) * P2_W'(cfg.gain_inv);
	// divider off behaves as a divide by one
	assign full_eff = cfg.div_en ? cfg.full_res : OHM_W'(1);
	assign tap_eff  = cfg.div_en ? cfg.tap_res  : OHM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1  <= P1_W'(raw_pos) * P1_W'(cfg.ref_mv);
			mv0_s2 <= p2 >> cfg.res_bits;
			num_s3 <= NUM_W'(mv0_s2) * NUM_W'(full_eff);
			// quotient would exceed 16 bits (or tap is zero)
			sat_s4 <= num_s3 >= NUM_W'({tap_eff, {MV_W{1'b0}}});
			rem_s4 <= num_s3[REM_W-1:0];
		end
	end

	assign out_valid = v_s4;
	assign out_sat   = sat_s4;
	assign out_rem   = rem_s4;

endmodule

`default_nettype wire

// File: rtl/core/blvl_div.sv
// ----------------------------------------------------------------------------
// blvl_div
// Pipelined restoring divider for a 16-bit quotient, two bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module blvl_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  blvl_pkg::cfg_t                 cfg,
	input  wire logic                      in_valid,
	input  wire logic                      in_sat,
	input  wire logic [blvl_pkg::REM_W-1:0] in_rem,
	output logic                           out_valid,
	output logic                           out_sat,
	output logic [blvl_pkg::MV_W-1:0]      out_quot
);
	import blvl_pkg::*;

	logic [OHM_W-1:0] tap_eff;

	logic             v_s   [0:DIV_STAGES];
	logic             sat_s [0:DIV_STAGES];
	logic [REM_W-1:0] rem_s [0:DIV_STAGES];
	logic [MV_W-1:0]  quo_s [0:DIV_STAGES];

	assign tap_eff  = cfg.div_en ? cfg.tap_res : OHM_W'(1);

	assign v_s[0]   = in_valid;
	assign sat_s[0] = in_sat;
	assign rem_s[0] = in_rem;
	assign quo_s[0] = '0;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [REM_W-1:0] rem_nx;
		logic [MV_W-1:0]  quo_nx;

		always_comb begin
			logic [REM_W-1:0] dsh;
			rem_nx = rem_s[g];
			quo_nx = quo_s[g];
			for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
				dsh = REM_W'(tap_eff) << (MV_W - 1 - (g * DIV_STEPS_PER_STAGE + k));
				if (rem_nx >= dsh) begin
					rem_nx = rem_nx - dsh;
					quo_nx = {quo_nx[MV_W-2:0], 1'b1};
				end else begin
					quo_nx = {quo_nx[MV_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[g+1] <= 1'b0;
			else if (en)
				v_s[g+1] <= v_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sat_s[g+1] <= sat_s[g];
				rem_s[g+1] <= rem_nx;
				quo_s[g+1] <= quo_nx;
			end
		end
	end

	assign out_valid = v_s[DIV_STAGES];
	assign out_sat   = sat_s[DIV_STAGES];
	assign out_quot  = quo_s[DIV_STAGES];

endmodule

`default_nettype wire

// File: rtl/core/blvl_level.sv
// ----------------------------------------------------------------------------
// blvl_level
// Saturation and table interpolation in three stages; last stage is the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blvl_level (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic                      in_sat,
	input  wire logic [blvl_pkg::MV_W-1:0] in_quot,
	output logic                           out_valid,
	output logic [blvl_pkg::MV_W-1:0]      out_mv,
	output logic [blvl_pkg::PCT_W-1:0]     out_pct
);
	import blvl_pkg::*;

	logic [MV_W-1:0]   mv;
	seg_t              seg;
	logic [D_W-1:0]    d;
	logic [RP_W-1:0]   rp;
	logic [PROD_W-1:0] qd;
	logic [PROD_W-1:0] rem;
	logic              bump;

	logic               v_s1, v_s2, v_s3;
	logic [MV_W-1:0]    mv_s1, mv_s2, mv_s3;
	logic [PROD_W-1:0]  p_s1, p_s2;
	logic [PCT_W-1:0]   pct_s1, pct_s2, pct_s3;
	logic [D_W-1:0]     den_s1, den_s2;
	logic [RECIP_W-1:0] recip_s1;
	logic [QEST_W-1:0]  qe_s2;

	assign mv   = in_sat ? '1 : in_quot;
	assign seg  = level_seg(mv);
	assign d    = D_W'(mv - seg.base_mv);
	// reciprocal estimate is exact or one low
	assign rp   = RP_W'(p_s1) * RP_W'(recip_s1);
	assign qd   = PROD_W'(QD_W'(qe_s2) * QD_W'(den_s2));
	assign rem  = p_s2 - qd;
	assign bump = rem >= PROD_W'(den_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mv_s1    <= mv;
			p_s1     <= PROD_W'(PROD_W'(seg.slope) * PROD_W'(d));
			pct_s1   <= seg.base_pct;
			den_s1   <= seg.den;
			recip_s1 <= seg.recip;

			mv_s2    <= mv_s1;
			p_s2     <= p_s1;
			pct_s2   <= pct_s1;
			den_s2   <= den_s1;
			qe_s2    <= rp[RECIP_SHIFT +: QEST_W];

			mv_s3    <= mv_s2;
			pct_s3   <= pct_s2 + PCT_W'(qe_s2) + PCT_W'(bump);
		end
	end

	assign out_valid = v_s3;
	assign out_mv    = mv_s3;
	assign out_pct   = pct_s3;

endmodule

`default_nettype wire

// File: rtl/core/battery_level_from_adc.sv
// ----------------------------------------------------------------------------
// battery_level_from_adc
// Raw ADC sample to battery millivolts and remaining level in percent.
// ----------------------------------------------------------------------------
// Pipeline: sample beat to result valid through 4 scale stages,
//   8 divider stages and 3 interpolation stages.
// Throughput: one sample beat per cycle unless the output stalls; set by
//   the fully pipelined datapath, two quotient bits per divider stage.
// Reset: arst_n clears all pipeline valid bits and loads the register
//   defaults (600 mV, gain 1/6, 14 bit, divider off, 1 ohm / 1 ohm).
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_from_adc (
	input  wire logic      clk,
	input  wire logic      arst_n,
	blvl_sample_if.sink    sample,
	blvl_result_if.source  result,
	blvl_cfg_if.sink       cfg
);
	import blvl_pkg::*;

	// Whole pipeline moves together; it holds only when the output register
	// is full and the downstream side is not taking the beat. An empty output
	// register never blocks, so bubbles alone never hold the pipe.
	logic en;

	cfg_t            cfg_regs;

	logic            sc_valid;
	logic            sc_sat;
	logic [REM_W-1:0] sc_rem;

	logic            dv_valid;
	logic            dv_sat;
	logic [MV_W-1:0] dv_quot;

	assign en           = !result.valid || result.ready;
	assign sample.ready = en;

	// Config writes are always taken and apply at once; they are only to be
	// issued while the block is idle.
	assign cfg.ready = 1'b1;

	blvl_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg.valid),
		.idx    (cfg.index),
		.wdata  (cfg.data),
		.cfg    (cfg_regs)
	);

	// Clamp negative readings, raw * ref * gain >> resolution, then form
	// the divider numerator (mV * full resistance) and flag results that
	// saturate at 65535. With the divider off the denominator is one.
	blvl_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (sample.valid),
		.raw_sample (sample.raw_sample),
		.cfg        (cfg_regs),
		.out_valid  (sc_valid),
		.out_sat    (sc_sat),
		.out_rem    (sc_rem)
	);

	// 16-bit quotient of numerator over tap resistance; only meaningful
	// when the saturation flag is clear.
	blvl_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.cfg       (cfg_regs),
		.in_valid  (sc_valid),
		.in_sat    (sc_sat),
		.in_rem    (sc_rem),
		.out_valid (dv_valid),
		.out_sat   (dv_sat),
		.out_quot  (dv_quot)
	);

	// Saturate, pick the table segment, interpolate with a constant
	// reciprocal plus one correction step. Last stage drives the result.
	blvl_level u_level (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.in_sat    (dv_sat),
		.in_quot   (dv_quot),
		.out_valid (result.valid),
		.out_mv    (result.battery_millivolts),
		.out_pct   (result.level_percent)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for battery_level_from_adc. Drives raw ADC samples and
// register writes over valid/ready channels. Each accepted sample is scored
// against an in-bench conversion to millivolts and table-based percent level.
// ----------------------------------------------------------------------------

module tb;

	import blvl_pkg::*;

	localparam int PIPE_LATENCY      = 15;      // sum of the DUT scale, divider and interpolation stages
	localparam int CYCLE_LIMIT       = 500000;
	localparam int NUM_PHASES        = 12;
	localparam int SAMPLES_PER_PHASE = 52;
	localparam int HOLD_CYCLES       = 200;     // long sink stall, well past pipe depth
	localparam int HOLD_PHASE        = 5;
	localparam int PAUSE_PHASE       = 7;
	localparam int FULL_SCALE_RAW    = 32767;

	// Index codes the DUT must ignore
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [MV_W-1:0]  mv;
		logic [PCT_W-1:0] pct;
	} reading_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	// One directed step: either a sample (optionally with a hand-typed answer)
	// or a register write. idx/data unused on sample rows.
	typedef struct packed {
		row_kind_t               kind;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_DATA_W-1:0]   data;
		logic signed [RAW_W-1:0] raw;
		logic                    typed;
		logic [MV_W-1:0]         mv;
		logic [PCT_W-1:0]        pct;
	} dir_row_t;

	localparam int NUM_ROWS = 37;

	localparam dir_row_t DIRECTED [NUM_ROWS] = '{
		// reset setting: 600 mV ref, gain 1/6, 14 bit, no divider
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd0,      1'b1, 16'd0,    7'd0},   // zero
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, -16'sd1,     1'b1, 16'd0,    7'd0},   // negative clamp
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, -16'sd32768, 1'b1, 16'd0,    7'd0},   // most negative
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd32767,  1'b1, 16'd7199, 7'd100}, // full scale
		// walk the table knees, each side
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd18205,  1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd18204,  1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd17522,  1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd16657,  1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd16156,  1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd14677,  1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd12744,  1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd12743,  1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sh4000,   1'b0, 16'd0,    7'd0},
		// zero gain
		'{ROW_WRITE,  REG_GAIN_INV, 24'd0, 16'sd0,    1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd32767,  1'b1, 16'd0,    7'd0},
		// zero reference, max gain
		'{ROW_WRITE,  REG_GAIN_INV, 24'd7, 16'sd0,    1'b0, 16'd0,    7'd0},
		'{ROW_WRITE,  REG_REF_MV, 24'd0, 16'sd0,      1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd32767,  1'b1, 16'd0,    7'd0},
		// max reference (upper data bits must be dropped), no shift: saturates
		'{ROW_WRITE,  REG_REF_MV, 24'hFFFFFF, 16'sd0, 1'b0, 16'd0,    7'd0},
		'{ROW_WRITE,  REG_RES_BITS, 24'd0, 16'sd0,    1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd32767,  1'b1, 16'd65535, 7'd100},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd1,      1'b0, 16'd0,    7'd0},
		// largest shift wipes everything out
		'{ROW_WRITE,  REG_RES_BITS, 24'd31, 16'sd0,   1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd32767,  1'b1, 16'd0,    7'd0},
		// divider on with zero tap leg: all-ones quotient
		'{ROW_WRITE,  REG_RES_BITS, 24'd16, 16'sd0,   1'b0, 16'd0,    7'd0},
		'{ROW_WRITE,  REG_DIV_EN, 24'd1, 16'sd0,      1'b0, 16'd0,    7'd0},
		'{ROW_WRITE,  REG_TAP_RES, 24'd0, 16'sd0,     1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd100,    1'b1, 16'd65535, 7'd100},
		// max legs
		'{ROW_WRITE,  REG_TAP_RES, 24'hFFFFFF, 16'sd0, 1'b0, 16'd0,   7'd0},
		'{ROW_WRITE,  REG_FULL_RES, 24'hFFFFFF, 16'sd0, 1'b0, 16'd0,  7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd32767,  1'b0, 16'd0,    7'd0},
		// zero full resistance
		'{ROW_WRITE,  REG_FULL_RES, 24'd0, 16'sd0,    1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd32767,  1'b1, 16'd0,    7'd0},
		// spare indexes: no effect, so still zero
		'{ROW_WRITE,  REG_SPARE_LO, 24'hFFFFFF, 16'sd0, 1'b0, 16'd0,  7'd0},
		'{ROW_WRITE,  REG_SPARE_HI, 24'd0, 16'sd0,    1'b0, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sd32767,  1'b1, 16'd0,    7'd0},
		'{ROW_SAMPLE, REG_REF_MV, 24'd0, 16'sh2AAA,   1'b0, 16'd0,    7'd0}
	};

	logic clk;
	logic arst_n;

	blvl_sample_if sample_ch ();
	blvl_result_if result_ch ();
	blvl_cfg_if    cfg_ch ();

	battery_level_from_adc DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Bench copy of the register file; tracks every accepted write beat
	cfg_t     adc_setting;
	reading_t pending_readings[$];   // expected results, oldest first
	int       mismatches;
	int       cycle_count;
	bit       sender_idle_on;
	bit       sink_idle_on;
	bit       sink_hold_req;

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- prediction

	// Millivolts before saturation; negative raw clamps to zero
	function automatic longint unsigned scaled_mv(input logic signed [RAW_W-1:0] raw,
		input cfg_t s);
		longint unsigned v;
		v = raw[RAW_W-1] ? 64'd0 : 64'(raw[RAW_W-2:0]);
		v = (v * s.ref_mv * s.gain_inv) >> s.res_bits;
		if (s.div_en) begin
			if (s.tap_res == '0)
				v = 64'd65535;
			else
				v = v * s.full_res / s.tap_res;
		end
		return v;
	endfunction

	// Seven-point table; the two 3225 mV points form a step from 5 to 10 percent
	function automatic logic [PCT_W-1:0] level_of_mv(input logic [MV_W-1:0] mv);
		int m;
		m = int'(mv);
		if (m >= 4000) return PCT_W'(100);
		if (m >= 3850) return PCT_W'(80 + 20 * (m - 3850) / 150);
		if (m >= 3660) return PCT_W'(50 + 30 * (m - 3660) / 190);
		if (m >= 3550) return PCT_W'(30 + 20 * (m - 3550) / 110);
		if (m >= 3225) return PCT_W'(10 + 20 * (m - 3225) / 325);
		if (m >= 2800) return PCT_W'(5 * (m - 2800) / 425);
		return PCT_W'(0);
	endfunction

	function automatic reading_t predict_reading(input logic signed [RAW_W-1:0] raw);
		longint unsigned v;
		reading_t r;
		v = scaled_mv(raw, adc_setting);
		r.mv  = (v > 64'd65535) ? '1 : MV_W'(v);
		r.pct = level_of_mv(r.mv);
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	// Mostly back-to-back, sometimes a few cycles, rarely a long gap
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Most samples are aimed into the 2.7..4.1 V window so every table
	// segment is hit; the rest are negatives and plain noise.
	function automatic logic signed [RAW_W-1:0] pick_raw();
		int r;
		longint unsigned full_mv;
		longint unsigned aim;
		r = $urandom_range(0, 99);
		full_mv = scaled_mv(RAW_W'(FULL_SCALE_RAW), adc_setting);
		if (r < 60 && full_mv >= 64'd2800) begin
			aim = 64'($urandom_range(2700, 4100)) * FULL_SCALE_RAW / full_mv;
			if (aim > FULL_SCALE_RAW)
				aim = FULL_SCALE_RAW;
			return RAW_W'(aim);
		end
		if (r < 75)
			return RAW_W'(-int'($urandom_range(1, 32768)));
		return RAW_W'($urandom);
	endfunction

	function automatic cfg_t pick_setting(input int phase);
		cfg_t s;
		case (phase)
			0: begin   // every field at its top
				s.ref_mv = '1; s.gain_inv = '1; s.res_bits = '1;
				s.div_en = 1'b1; s.full_res = '1; s.tap_res = '1;
			end
			1: begin   // every field at zero
				s = '0;
			end
			2: begin   // no shift, saturating
				s.ref_mv = '1; s.gain_inv = '1; s.res_bits = '0; s.div_en = 1'b0;
				s.full_res = OHM_W'($urandom); s.tap_res = OHM_W'($urandom);
			end
			3: begin   // zero tap leg under divider
				s.ref_mv = RST_REF_MV; s.gain_inv = RST_GAIN_INV;
				s.res_bits = RST_RES_BITS; s.div_en = 1'b1;
				s.full_res = OHM_W'($urandom); s.tap_res = '0;
			end
			default: begin
				if ($urandom_range(0, 2) != 0) begin
					// plausible hardware: sane ref/gain/resolution, modest ratio
					s.ref_mv   = REF_W'($urandom_range(1, 5000));
					s.gain_inv = GAIN_W'($urandom_range(1, 6));
					s.res_bits = RES_W'($urandom_range(8, 16));
					s.div_en   = 1'($urandom);
					s.tap_res  = OHM_W'($urandom_range(1, 1000000));
					s.full_res = s.tap_res * OHM_W'($urandom_range(1, 3))
						+ OHM_W'($urandom_range(0, s.tap_res));
				end else begin
					s.ref_mv   = REF_W'($urandom);
					s.gain_inv = GAIN_W'($urandom);
					s.res_bits = RES_W'($urandom);
					s.div_en   = 1'($urandom);
					s.full_res = OHM_W'($urandom);
					s.tap_res  = OHM_W'($urandom);
				end
			end
		endcase
		return s;
	endfunction

	// ---------------------------------------------------------------- channel tasks
	// All tasks are entered and left at a falling edge.

	// Leaves cfg valid high so back-to-back writes never toggle it in one step
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_REF_MV:   adc_setting.ref_mv   = data[REF_W-1:0];
			REG_GAIN_INV: adc_setting.gain_inv = data[GAIN_W-1:0];
			REG_RES_BITS: adc_setting.res_bits = data[RES_W-1:0];
			REG_DIV_EN:   adc_setting.div_en   = data[0];
			REG_FULL_RES: adc_setting.full_res = data[OHM_W-1:0];
			REG_TAP_RES:  adc_setting.tap_res  = data[OHM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Junk above each field width checks that the DUT drops it
	task automatic apply_setting(input cfg_t s);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'($urandom); d[REF_W-1:0] = s.ref_mv;
		write_reg(REG_REF_MV, d);
		d = CFG_DATA_W'($urandom); d[GAIN_W-1:0] = s.gain_inv;
		write_reg(REG_GAIN_INV, d);
		d = CFG_DATA_W'($urandom); d[RES_W-1:0] = s.res_bits;
		write_reg(REG_RES_BITS, d);
		d = CFG_DATA_W'($urandom); d[0] = s.div_en;
		write_reg(REG_DIV_EN, d);
		write_reg(REG_FULL_RES, s.full_res);
		write_reg(REG_TAP_RES, s.tap_res);
		cfg_ch.valid <= 1'b0;
	endtask

	// Sample beat; expectation is taken at acceptance with the live setting
	task automatic send_sample(input logic signed [RAW_W-1:0] raw, input bit typed,
		input reading_t typed_reading);
		int gap;
		if (cfg_ch.valid)
			cfg_ch.valid <= 1'b0;
		gap = sender_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.raw_sample <= raw;
		do @(posedge clk); while (!sample_ch.ready);
		pending_readings.push_back(typed ? typed_reading : predict_reading(raw));
		@(negedge clk);
	endtask

	// Stop offering and let every expected result come back
	task automatic wait_drained();
		if (sample_ch.valid || pending_readings.size() != 0) begin
			sample_ch.valid <= 1'b0;
			while (pending_readings.size() != 0)
				@(posedge clk);
			@(negedge clk);
		end
	endtask

	// ---------------------------------------------------------------- result side

	// Sink ready: random gaps, or one long hold when the main flow asks
	initial begin : sink_driver
		int gap;
		gap = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!sink_idle_on || gap == 0) begin
				result_ch.ready <= 1'b1;
				gap = sink_idle_on ? pick_gap() : 0;
			end else begin
				result_ch.ready <= 1'b0;
				gap--;
			end
		end
	end

	// Score every result beat against the oldest expectation
	always @(posedge clk) begin : result_check
		reading_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_readings.size() == 0) begin
				$error("unexpected result beat: battery_millivolts %0d, level_percent %0d",
					result_ch.battery_millivolts, result_ch.level_percent);
				mismatches++;
			end else begin
				want = pending_readings.pop_front();
				if (result_ch.battery_millivolts !== want.mv) begin
					$error("battery_millivolts: expected %0d, actual %0d",
						want.mv, result_ch.battery_millivolts);
					mismatches++;
				end
				if (result_ch.level_percent !== want.pct) begin
					$error("level_percent: expected %0d, actual %0d",
						want.pct, result_ch.level_percent);
					mismatches++;
				end
			end
		end
	end

	// Hang guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("battery_level_from_adc verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- main flow

	initial begin : main_flow
		reading_t typed_reading;
		dir_row_t row;

		clk                  = 1'b0;
		arst_n               = 1'b0;
		sample_ch.valid      = 1'b0;
		sample_ch.raw_sample = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = '0;
		cfg_ch.data          = '0;
		mismatches           = 0;
		cycle_count          = 0;
		sender_idle_on       = 1'b1;
		sink_idle_on         = 1'b1;
		sink_hold_req        = 1'b0;

		adc_setting.ref_mv   = RST_REF_MV;
		adc_setting.gain_inv = RST_GAIN_INV;
		adc_setting.res_bits = RST_RES_BITS;
		adc_setting.div_en   = RST_DIV_EN;
		adc_setting.full_res = RST_FULL_RES;
		adc_setting.tap_res  = RST_TAP_RES;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed table; writes only once the pipe is empty
		for (int i = 0; i < NUM_ROWS; i++) begin
			row = DIRECTED[i];
			if (row.kind == ROW_WRITE) begin
				wait_drained();
				write_reg(row.idx, row.data);
			end else begin
				typed_reading.mv  = row.mv;
				typed_reading.pct = row.pct;
				send_sample(row.raw, row.typed, typed_reading);
			end
		end

		// Random phases: new setting each time, extremes first
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_drained();
			apply_setting(pick_setting(phase));
			// every fourth phase runs flat out on both sides
			sender_idle_on = (phase % 4 != 3);
			sink_idle_on   = (phase % 4 != 3);
			if (phase == HOLD_PHASE) begin
				// sink holds off while the sender keeps pushing: pipe fills, input stalls
				sender_idle_on = 1'b0;
				sink_hold_req  = 1'b1;
			end
			for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
				if (phase == PAUSE_PHASE && n == SAMPLES_PER_PHASE / 2)
					wait_drained();
				send_sample(pick_raw(), 1'b0, '0);
			end
		end

		wait_drained();
		repeat (PIPE_LATENCY + 5) @(posedge clk);
		if (mismatches == 0)
			$display("battery_level_from_adc verification clean");
		else
			$display("battery_level_from_adc verification failed");
		$finish;
	end

endmodule
